@@ rtl/core/rmq_pkg.sv @@
// Package for the running median queue: status codes, controller states and
// the command and status structs between controller and datapath. No dependencies.
package rmq_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic dummy;
	} dp_stat_t;

endpackage

@@ rtl/core/rmq_if.sv @@
// Valid/ready channel interface for the running median queue.
// Depends on nothing; the payload type is a parameter.
interface rmq_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmq_ctrl.sv @@
// Controller of the running median queue: sequences load, shift and result.
// Depends on rmq_pkg.
module rmq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rmq_pkg::dp_stat_t stat,
	output rmq_pkg::dp_cmd_t  cmd
);
	import rmq_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_n = S_EXEC;
			S_EXEC: state_n = S_OUT;
			S_OUT: begin
				if (out_ready) state_n = in_valid ? S_EXEC : S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
		out_valid = (state_q == S_OUT);
		cmd.load  = in_ready && in_valid && !stat.dummy;
		cmd.exec  = (state_q == S_EXEC);
	end
endmodule

@@ rtl/core/rmq_dp.sv @@
// Datapath of the running median queue: a sorted chain of cells that shift
// toward or away from their neighbors. Depends on rmq_pkg.
module rmq_dp #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmq_pkg::dp_cmd_t              cmd,
	output rmq_pkg::dp_stat_t             stat,
	input  logic                          in_kind,
	input  logic signed [VALUE_WIDTH-1:0] in_value,
	output logic signed [VALUE_WIDTH-1:0] removed_value,
	output logic signed [VALUE_WIDTH-1:0] median_now,
	output logic [CW-1:0]                 count_now,
	output logic [1:0]                    status
);
	import rmq_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic signed [VALUE_WIDTH-1:0] cell_q [CAPACITY];
	logic [CW-1:0]                 count_q;
	logic                          kind_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic [CW-1:0]                 midx;
	logic [AW-1:0]                 mid_a;
	logic [CW-1:0]                 cnt_m1;
	logic [CAPACITY-1:0]           gt;

	assign stat.dummy = 1'b0;
	assign cnt_m1 = count_q - CW'(1);
	assign midx = cnt_m1 >> 1;
	assign mid_a = midx[AW-1:0];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CW'(i) < count_q) && (cell_q[i] > value_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
		if (cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!kind_q) begin
					if (count_q != CW'(CAPACITY)) begin
						if (i > 0 && gt[i]) begin
							if (gt[i-1]) cell_q[i] <= cell_q[i-1];
							else cell_q[i] <= value_q;
						end else if (i == 0 && gt[0]) begin
							cell_q[0] <= value_q;
						end else if (CW'(i) == count_q) begin
							if (i > 0 && gt[i-1]) cell_q[i] <= cell_q[i-1];
							else cell_q[i] <= value_q;
						end
					end
				end else if (count_q != '0) begin
					if (CW'(i) >= midx && i < CAPACITY - 1) cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			status  <= ST_OK;
		end else if (cmd.exec) begin
			if (!kind_q) begin
				if (count_q == CW'(CAPACITY)) status <= ST_FULL;
				else begin
					status  <= ST_OK;
					count_q <= count_q + CW'(1);
				end
			end else if (count_q == '0) begin
				status <= ST_EMPTY;
			end else begin
				status  <= ST_OK;
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			removed_value <= (kind_q && count_q != '0) ? cell_q[mid_a] : '0;
		end
	end

	// The median is read from the settled cells after the step.
	assign median_now = (count_q == '0) ? '0 : cell_q[mid_a];

	assign count_now = count_q;
endmodule

@@ rtl/core/running_median_queue.sv @@
// Top level of the running median queue; depends on rmq_pkg, rmq_if,
// rmq_ctrl and rmq_dp.
//
// Channel | Direction | Payload
// in_ch   | sink      | kind, value
// out_ch  | source    | removed_value, median_now, count_now, status
//
// Each transaction is first captured, then shifts the cell chain in a separate step.
// A result is held until taken; the next input is taken in the same cycle.
// Reset empties the store at once; cell contents are not cleared.
module running_median_queue #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rmq_if.sink   in_ch,
	rmq_if.source out_ch
);
	import rmq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic signed [VALUE_WIDTH-1:0] rv, mn;
	logic [CW-1:0] cn;
	logic [1:0]    st;

	rmq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	rmq_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_kind(in_ch.data.kind), .in_value(in_ch.data.value),
		.removed_value(rv), .median_now(mn), .count_now(cn), .status(st)
	);

	assign out_ch.data.removed_value = rv;
	assign out_ch.data.median_now    = mn;
	assign out_ch.data.count_now     = 7'(cn);
	assign out_ch.data.status        = st;

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cn <= CW'(CAPACITY)) else $error("count beyond capacity");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && st == ST_EMPTY |-> cn == '0) else $error("empty flag with data");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && st == ST_FULL |-> cn == CW'(CAPACITY)) else $error("full flag wrong");
endmodule

@@ verif/running_median_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for running_median_queue: directed and random insert and remove
// transactions, checked against a sorted-list model. Depends on rmq_pkg and rmq_if.

module running_median_queue_tb;
	import rmq_pkg::*;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;
	localparam int   DEPTH       = 64;
	localparam int   NUM_ITEMS   = 1800;
	localparam int   QUIET_FROM  = 1500;
	localparam int   STALL_LIMIT = 2000;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic signed [31:0] median_now;
		logic [6:0]         count_now;
		logic [1:0]         status;
	} out_t;

	class median_scoreboard;
		logic signed [31:0] sorted_vals[$];
		out_t               awaited[$];
		int                 errors;
		int                 n_insert, n_remove, n_full, n_empty;

		function void note(in_t t);
			out_t e;
			int   pos;
			e = '0;
			e.status = ST_OK;
			if (t.kind == KIND_INSERT) begin
				n_insert++;
				if (sorted_vals.size() >= DEPTH) begin
					e.status = ST_FULL;
					n_full++;
				end else begin
					pos = 0;
					while (pos < sorted_vals.size() && sorted_vals[pos] <= t.value)
						pos++;
					sorted_vals.insert(pos, t.value);
				end
			end else begin
				n_remove++;
				if (sorted_vals.size() == 0) begin
					e.status = ST_EMPTY;
					n_empty++;
				end else begin
					pos = (sorted_vals.size() - 1) / 2;
					e.removed_value = sorted_vals[pos];
					sorted_vals.delete(pos);
				end
			end
			if (sorted_vals.size() != 0)
				e.median_now = sorted_vals[(sorted_vals.size() - 1) / 2];
			e.count_now = 7'(sorted_vals.size());
			awaited.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		endtask

		task check(out_t r);
			out_t e;
			if (awaited.size() == 0) begin
				report("unexpected result, count_now", r.count_now, -1);
			end else begin
				e = awaited.pop_front();
				if (r.removed_value !== e.removed_value)
					report("removed_value", r.removed_value, e.removed_value);
				if (r.median_now !== e.median_now)
					report("median_now", r.median_now, e.median_now);
				if (r.count_now !== e.count_now)
					report("count_now", r.count_now, e.count_now);
				if (r.status !== e.status)
					report("status", r.status, e.status);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic quiet;
	int   sent;
	int   stall_cycles;
	int   ready_hold;
	median_scoreboard board;

	rmq_if #(.payload_t(in_t))  in_ch ();
	rmq_if #(.payload_t(out_t)) out_ch ();

	running_median_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			board.note(in_ch.data);
		if (out_ch.valid && out_ch.ready)
			board.check(out_ch.data);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready = 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			out_ch.ready = 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			ready_hold = $urandom_range(1, 17) - 1;
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000 + $urandom_range(0, 2);
			1: return 32'sh7fff_ffff - $urandom_range(0, 2);
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send(logic kind, logic signed [31:0] value);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			repeat (gap) begin
				@(negedge clk);
				in_ch.valid      = 1'b0;
				in_ch.data.kind  = 1'($urandom());
				in_ch.data.value = $signed($urandom());
			end
		end
		@(negedge clk);
		in_ch.valid      = 1'b1;
		in_ch.data.kind  = kind;
		in_ch.data.value = value;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	initial begin
		int seg_len, mode, ins_pct, wait_cycles;
		clk          = 1'b0;
		arst_n       = 1'b0;
		quiet        = 1'b0;
		sent         = 0;
		stall_cycles = 0;
		ready_hold   = 0;
		board        = new();
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: removal from empty, extremes, equal values, drain past empty.
		send(KIND_REMOVE, 32'sh1234_5678);
		send(KIND_INSERT, 32'sh8000_0000);
		send(KIND_INSERT, 32'sh7fff_ffff);
		send(KIND_INSERT, 32'sh0000_0000);
		send(KIND_INSERT, -32'sd1);
		send(KIND_INSERT, 32'sd5);
		send(KIND_INSERT, 32'sd5);
		send(KIND_INSERT, 32'sd5);
		send(KIND_INSERT, -32'sd1);
		repeat (9) send(KIND_REMOVE, -32'sd1);
		send(KIND_INSERT, 32'sh7fff_ffff);
		send(KIND_INSERT, 32'sh7fff_ffff);
		send(KIND_REMOVE, 32'sh0);
		send(KIND_REMOVE, 32'sh0);

		// Random segments: fill toward full, drain toward empty, or mix.
		while (sent < NUM_ITEMS) begin
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(20, 90);
			case (mode)
				0: ins_pct = 90;
				1: ins_pct = 20;
				2: ins_pct = 55;
				default: ins_pct = 100;
			endcase
			repeat (seg_len) begin
				if (sent >= QUIET_FROM)
					quiet = 1'b1;
				if ($urandom_range(1, 100) <= ins_pct)
					send(KIND_INSERT, pick_value());
				else
					send(KIND_REMOVE, $signed($urandom()));
			end
		end

		@(negedge clk);
		in_ch.valid = 1'b0;
		wait_cycles = 0;
		while (board.awaited.size() != 0 && wait_cycles < STALL_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);

		$display("covered %0d inserts (%0d into a full store) and %0d removals (%0d from empty)",
			board.n_insert, board.n_full, board.n_remove, board.n_empty);
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results missing", board.errors,
				board.awaited.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rmq_pkg.sv
rtl/core/rmq_if.sv
rtl/core/rmq_ctrl.sv
rtl/core/rmq_dp.sv
rtl/core/running_median_queue.sv
verif/running_median_queue_tb.sv
